// ----- design/tbi_pkg.sv -----
package tbi_pkg;

    typedef enum logic [1:0] {
        OP_WRITE_LOAD = 2'd0,
        OP_WRITE_SLIP = 2'd1,
        OP_WRITE_GRID = 2'd2,
        OP_QUERY      = 2'd3
    } op_t;

    localparam int WFRAC = 16;

    localparam int LOAD_POINTS = 16;
    localparam int SLIP_POINTS = 64;

    localparam logic [0:0] REG_LOAD_POINTS = 1'b0;
    localparam logic [0:0] REG_SLIP_POINTS = 1'b1;

    typedef struct packed {
        logic               start;
        logic signed [33:0] num;
        logic signed [33:0] den;
    } div_req_t;

endpackage

// ----- design/tbi_divider.sv -----
module tbi_divider
    import tbi_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  div_req_t           req,
    output logic               done,
    output logic signed [25:0] weight
);

    localparam int NB = 50;

    logic [NB-1:0]  rem_reg, rem_next;
    logic [NB-1:0]  quo_reg, quo_next;
    logic [NB-1:0]  num_reg, num_next;
    logic [33:0]    den_reg, den_next;
    logic           neg_reg, neg_next;
    logic           zero_reg, zero_next;
    logic [5:0]     cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [33:0]    un, ud;
    logic [NB-1:0]  shifted;
    logic [NB-1:0]  q_sat;

    always_comb
    begin
        un = req.num[33] ? 34'(-req.num) : 34'(req.num);
        ud = req.den[33] ? 34'(-req.den) : 34'(req.den);
        shifted = {rem_reg[NB-2:0], num_reg[NB-1]};
        rem_next = rem_reg;
        quo_next = quo_reg;
        num_next = num_reg;
        den_next = den_reg;
        neg_next = neg_reg;
        zero_next = zero_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            // Numerator is (|num| << 16) + |den|/2, exact rounding by half.
            num_next = ({16'd0, un} << WFRAC) + NB'(ud >> 1);
            den_next = ud;
            neg_next = req.num[33] ^ req.den[33];
            zero_next = (req.den == '0);
            rem_next = '0;
            quo_next = '0;
            cnt_next = 6'(NB);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= NB'(den_reg))
            begin
                rem_next = shifted - NB'(den_reg);
                quo_next = {quo_reg[NB-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[NB-2:0], 1'b0};
            end
            num_next = {num_reg[NB-2:0], 1'b0};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
    end

    assign q_sat = (quo_reg > NB'(1 << 24)) ? NB'(1 << 24) : quo_reg;
    assign done = done_reg;
    assign weight = zero_reg ? 26'sd0 :
                    neg_reg ? -$signed(26'(q_sat)) : $signed(26'(q_sat));

endmodule

// ----- design/table_bilinear_interpolator.sv -----
// Table bilinear interpolator: a write passes through one write state before the next word is taken;
// a query's length is set by the axis scans, which read one point at a time from the axis
// memories, and by the two 50-step bit-serial weight divisions.
// One item is processed at a time; a finished result waits in an output register
// while the next item is taken.
// rst_n clears control state and sets the point counts to their maximum; memories are not cleared.
module table_bilinear_interpolator
    import tbi_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [6:0]   cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // operation[1:0], row_index[7:2], column_index[11:8], entry_value[43:12],
    // query_load[75:44], query_slip[107:76], zeros above.
    input  logic [111:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // interpolated_value[31:0], load_outside[32], slip_clamped[33], zeros above.
    output logic [39:0]  m_tdata
);

    localparam int LW = $clog2(LOAD_POINTS);
    localparam int SW = $clog2(SLIP_POINTS);
    localparam int GW = LW + SW;

    typedef enum logic [4:0] {
        S_IDLE, S_WRITE, S_LSCAN, S_LEND, S_LRD0, S_LRD1,
        S_SSCAN, S_SLAST, S_SRD0, S_SRD1,
        S_DIVX, S_WAITX, S_DIVY, S_WAITY,
        S_G0, S_G1, S_G2, S_G3, S_G4, S_BLA, S_BLB, S_BLR, S_OUT
    } state_t;

    logic signed [31:0] load_mem [LOAD_POINTS];
    logic signed [31:0] slip_mem [SLIP_POINTS];
    logic signed [31:0] grid_mem [SLIP_POINTS*LOAD_POINTS];

    logic [LW-1:0]      la_addr;
    logic [SW-1:0]      sa_addr;
    logic [GW-1:0]      ga_addr;
    logic signed [31:0] la_q, sa_q, ga_q;

    state_t             state_reg;
    logic [1:0]         op_reg;
    logic [5:0]         row_reg;
    logic [3:0]         col_reg;
    logic signed [31:0] val_reg, xq_reg, yq_reg;
    logic [6:0]         nl_reg, ns_reg;
    logic [6:0]         lp_used_reg, sp_used_reg;
    logic [8:0]         i_reg, j_reg;
    logic               lflag_reg, sflag_reg, found_reg;
    logic signed [31:0] first_reg, x0_reg, x1_reg, y0_reg, y1_reg;
    logic signed [31:0] v00_reg, v01_reg, v10_reg, v11_reg;
    logic signed [25:0] tx_reg, ty_reg;
    logic signed [33:0] a_reg, b_reg;
    logic signed [33:0] bl_v0, bl_v1;
    logic signed [25:0] bl_t;
    logic signed [33:0] bl_out;
    logic               out_valid_reg;
    logic [33:0]        out_reg;
    div_req_t           dreq;
    logic               ddone;
    logic signed [25:0] dweight;
    logic [1:0]         gstep_reg;

    // One-dimensional blend with rounding half away from zero and saturation.
    function automatic logic signed [33:0] blend_f(input logic signed [33:0] v0,
                                                   input logic signed [33:0] v1,
                                                   input logic signed [25:0] t);
        logic signed [34:0] d;
        logic [34:0]        md;
        logic [25:0]        mt;
        logic [60:0]        p;
        logic [44:0]        r;
        logic signed [46:0] s;
        begin
            d  = 35'(v1) - 35'(v0);
            md = d[34] ? 35'(-d) : 35'(d);
            mt = t[25] ? 26'(-t) : 26'(t);
            p  = 61'(md) * 61'(mt);
            r  = 45'((p + 61'(1 << (WFRAC - 1))) >> WFRAC);
            s  = (d[34] ^ t[25]) ? 47'(v0) - 47'(r) : 47'(v0) + 47'(r);
            if (s > 47'sd2147483647)
                blend_f = 34'sd2147483647;
            else if (s < -47'sd2147483648)
                blend_f = -34'sd2147483648;
            else
                blend_f = 34'(s);
        end
    endfunction

    tbi_divider u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (dreq),
        .done   (ddone),
        .weight (dweight)
    );

    always_ff @(posedge clk)
    begin
        la_q <= load_mem[la_addr];
        sa_q <= slip_mem[sa_addr];
        ga_q <= grid_mem[ga_addr];
        if (state_reg == S_WRITE)
        begin
            if (op_reg == OP_WRITE_LOAD && 32'(col_reg) < LOAD_POINTS)
                load_mem[col_reg[LW-1:0]] <= val_reg;
            if (op_reg == OP_WRITE_SLIP && 32'(row_reg) < SLIP_POINTS)
                slip_mem[row_reg[SW-1:0]] <= val_reg;
            if (op_reg == OP_WRITE_GRID && 32'(row_reg) < SLIP_POINTS
                && 32'(col_reg) < LOAD_POINTS)
                grid_mem[{row_reg[SW-1:0], col_reg[LW-1:0]}] <= val_reg;
        end
    end

    always_comb
    begin
        la_addr = i_reg[LW-1:0];
        sa_addr = j_reg[SW-1:0];
        ga_addr = '0;
        case (gstep_reg)
            2'd0: ga_addr = {j_reg[SW-1:0] - SW'(1), i_reg[LW-1:0] - LW'(1)};
            2'd1: ga_addr = {j_reg[SW-1:0] - SW'(1), i_reg[LW-1:0]};
            2'd2: ga_addr = {j_reg[SW-1:0], i_reg[LW-1:0] - LW'(1)};
            default: ga_addr = {j_reg[SW-1:0], i_reg[LW-1:0]};
        endcase
        dreq.start = (state_reg == S_DIVX) || (state_reg == S_DIVY);
        if (state_reg == S_DIVX)
        begin
            dreq.num = 34'(xq_reg) - 34'(x0_reg);
            dreq.den = 34'(x1_reg) - 34'(x0_reg);
        end
        else
        begin
            dreq.num = 34'(yq_reg) - 34'(y0_reg);
            dreq.den = 34'(y1_reg) - 34'(y0_reg);
        end
        bl_v0 = a_reg;
        bl_v1 = b_reg;
        bl_t  = ty_reg;
        case (state_reg)
            S_BLA:
            begin
                bl_v0 = 34'(v00_reg);
                bl_v1 = 34'(v01_reg);
                bl_t  = tx_reg;
            end
            S_BLB:
            begin
                bl_v0 = 34'(v10_reg);
                bl_v1 = 34'(v11_reg);
                bl_t  = tx_reg;
            end
            default:
            begin
            end
        endcase
        bl_out = blend_f(bl_v0, bl_v1, bl_t);
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            lp_used_reg   <= 7'd16;
            sp_used_reg   <= 7'd64;
            gstep_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_LOAD_POINTS)
                    lp_used_reg <= {2'd0, cfg_data[4:0]};
                else
                    sp_used_reg <= cfg_data;
            end
            if (m_tvalid && m_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        op_reg  <= s_tdata[1:0];
                        row_reg <= s_tdata[7:2];
                        col_reg <= s_tdata[11:8];
                        val_reg <= s_tdata[43:12];
                        xq_reg  <= s_tdata[75:44];
                        yq_reg  <= s_tdata[107:76];
                        nl_reg  <= (lp_used_reg < 7'd2) ? 7'd2 :
                                   (32'(lp_used_reg) > LOAD_POINTS) ? 7'(LOAD_POINTS)
                                   : lp_used_reg;
                        ns_reg  <= (sp_used_reg < 7'd2) ? 7'd2 :
                                   (32'(sp_used_reg) > SLIP_POINTS) ? 7'(SLIP_POINTS)
                                   : sp_used_reg;
                        i_reg     <= 9'd0;
                        found_reg <= 1'b0;
                        state_reg <= (s_tdata[1:0] == OP_QUERY) ? S_LSCAN : S_WRITE;
                    end
                end
                S_WRITE: state_reg <= S_IDLE;
                S_LSCAN:
                begin
                    // Address i issued; data lands next cycle.
                    state_reg <= S_LEND;
                end
                S_LEND:
                begin
                    if (i_reg == 9'd0)
                    begin
                        first_reg <= la_q;
                        i_reg     <= 9'd1;
                        state_reg <= S_LSCAN;
                    end
                    else if (!found_reg && (i_reg < 9'(nl_reg) - 9'd1)
                             && !(xq_reg > la_q))
                    begin
                        i_reg     <= i_reg + 9'd1;
                        state_reg <= S_LSCAN;
                    end
                    else if (!found_reg)
                    begin
                        found_reg <= 1'b1;
                        x1_reg    <= la_q;
                        j_reg     <= 9'(i_reg);
                        i_reg     <= 9'(nl_reg) - 9'd1;
                        state_reg <= S_LSCAN;
                    end
                    else
                    begin
                        lflag_reg <= (xq_reg > first_reg) || (xq_reg < la_q);
                        i_reg     <= j_reg - 9'd1;
                        state_reg <= S_LRD0;
                    end
                end
                S_LRD0: state_reg <= S_LRD1;
                S_LRD1:
                begin
                    x0_reg    <= la_q;
                    i_reg     <= i_reg + 9'd1;
                    j_reg     <= 9'd1;
                    sflag_reg <= 1'b0;
                    state_reg <= S_SSCAN;
                end
                S_SSCAN: state_reg <= S_SLAST;
                S_SLAST:
                begin
                    if (yq_reg < sa_q)
                    begin
                        y1_reg    <= sa_q;
                        j_reg     <= j_reg - 9'd1;
                        state_reg <= S_SRD0;
                    end
                    else if (j_reg + 9'd1 < 9'(ns_reg))
                    begin
                        j_reg     <= j_reg + 9'd1;
                        state_reg <= S_SSCAN;
                    end
                    else
                    begin
                        y1_reg    <= sa_q;
                        sflag_reg <= yq_reg > sa_q;
                        yq_reg    <= sa_q;
                        j_reg     <= j_reg - 9'd1;
                        state_reg <= S_SRD0;
                    end
                end
                S_SRD0: state_reg <= S_SRD1;
                S_SRD1:
                begin
                    y0_reg    <= sa_q;
                    j_reg     <= j_reg + 9'd1;
                    state_reg <= S_DIVX;
                end
                S_DIVX: state_reg <= S_WAITX;
                S_WAITX:
                begin
                    if (ddone)
                    begin
                        tx_reg    <= dweight;
                        state_reg <= S_DIVY;
                    end
                end
                S_DIVY: state_reg <= S_WAITY;
                S_WAITY:
                begin
                    if (ddone)
                    begin
                        ty_reg    <= dweight;
                        gstep_reg <= 2'd0;
                        state_reg <= S_G0;
                    end
                end
                S_G0:
                begin
                    gstep_reg <= 2'd1;
                    state_reg <= S_G1;
                end
                S_G1:
                begin
                    v00_reg   <= ga_q;
                    gstep_reg <= 2'd2;
                    state_reg <= S_G2;
                end
                S_G2:
                begin
                    v01_reg   <= ga_q;
                    gstep_reg <= 2'd3;
                    state_reg <= S_G3;
                end
                S_G3:
                begin
                    v10_reg   <= ga_q;
                    state_reg <= S_G4;
                end
                S_G4:
                begin
                    v11_reg   <= ga_q;
                    state_reg <= S_BLA;
                end
                S_BLA:
                begin
                    a_reg     <= bl_out;
                    state_reg <= S_BLB;
                end
                S_BLB:
                begin
                    b_reg     <= bl_out;
                    state_reg <= S_BLR;
                end
                S_BLR:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg)
                    begin
                        out_reg       <= {sflag_reg, lflag_reg, bl_out[31:0]};
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word dropped while stalled");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_tready)
        else $error("input taken while busy");
    a_out_from_blend: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_OUT))
        else $error("result without a finished query");

endmodule

// ----- sim/table_bilinear_interpolator_test.sv -----
module table_bilinear_interpolator_test;
    import tbi_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        op_t                op;
        logic [5:0]         row;
        logic [3:0]         col;
        logic signed [31:0] val;
        logic signed [31:0] qload;
        logic signed [31:0] qslip;
    } word_t;

    typedef struct {
        logic signed [31:0] value;
        logic               load_out;
        logic               slip_clamp;
    } answer_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic         cfg_index = REG_LOAD_POINTS;
    logic [6:0]   cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [39:0]  m_tdata;

    table_bilinear_interpolator dut (.*);

    always #5 clk = ~clk;

    // Predictor state, updated when a word is accepted.
    logic signed [31:0] load_tab [16];
    logic signed [31:0] slip_tab [64];
    logic signed [31:0] grid_tab [1024];
    logic [4:0]         load_used = 5'd16;
    logic [6:0]         slip_used = 7'd64;
    // Tables as they will be once every queued word has been taken.
    logic signed [31:0] plan_load [16];
    logic signed [31:0] plan_slip [64];

    word_t   pending_words [$];
    answer_t expected_answers [$];
    word_t   cur_word;
    logic    holding = 1'b0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      recv_block_left = 0;
    int      errors = 0;
    int      n_queries = 0;
    int      n_writes = 0;
    int      n_load_out = 0;
    int      n_slip_clamp = 0;

    function automatic longint unsigned magn(longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint ratio_weight(longint num, longint den);
        longint unsigned un, ud, q;
        if (den == 0) return 0;
        un = magn(num);
        ud = magn(den);
        q = ((un << WFRAC) + ud / 2) / ud;
        if (q > (64'd1 << 24)) q = 64'd1 << 24;
        return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint lerp(longint v0, longint v1, longint t);
        longint d;
        longint unsigned p, r;
        d = v1 - v0;
        p = magn(d) * magn(t);
        r = (p + (64'd1 << (WFRAC - 1))) >> WFRAC;
        return sat32(((d < 0) != (t < 0)) ? v0 - longint'(r) : v0 + longint'(r));
    endfunction

    function automatic answer_t interpolate(logic signed [31:0] ql, logic signed [31:0] qs);
        answer_t a;
        longint xq, yq, tx, ty, top, bot;
        int nl, ns, i, j;
        xq = ql;
        yq = qs;
        nl = load_used < 2 ? 2 : (load_used > 16 ? 16 : load_used);
        ns = slip_used < 2 ? 2 : (slip_used > 64 ? 64 : slip_used);
        i = 1;
        while (i < nl - 1 && !(xq > longint'(load_tab[i]))) i++;
        a.load_out = xq > longint'(load_tab[0]) || xq < longint'(load_tab[nl - 1]);
        a.slip_clamp = 1'b0;
        j = 1;
        while (j < ns && !(yq < longint'(slip_tab[j]))) j++;
        if (j >= ns) begin
            j = ns - 1;
            a.slip_clamp = yq > longint'(slip_tab[j]);
            yq = slip_tab[j];
        end
        tx = ratio_weight(xq - load_tab[i - 1], longint'(load_tab[i]) - load_tab[i - 1]);
        ty = ratio_weight(yq - slip_tab[j - 1], longint'(slip_tab[j]) - slip_tab[j - 1]);
        top = lerp(grid_tab[(j - 1) * 16 + i - 1], grid_tab[(j - 1) * 16 + i], tx);
        bot = lerp(grid_tab[j * 16 + i - 1], grid_tab[j * 16 + i], tx);
        a.value = 32'(lerp(top, bot, ty));
        return a;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    endtask

    // Sender: words change at the falling edge.
    always @(negedge clk) begin
        if (rst_n && !holding) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                cur_word = pending_words.pop_front();
                s_tdata <= {4'b0, cur_word.qslip, cur_word.qload, cur_word.val,
                            cur_word.col, cur_word.row, cur_word.op};
                s_tvalid <= 1'b1;
                holding = 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if (rst_n && s_tvalid && s_tready) begin
            holding = 1'b0;
            case (cur_word.op)
                OP_WRITE_LOAD: load_tab[cur_word.col] = cur_word.val;
                OP_WRITE_SLIP: slip_tab[cur_word.row] = cur_word.val;
                OP_WRITE_GRID: grid_tab[cur_word.row * 16 + cur_word.col] = cur_word.val;
                default: expected_answers.push_back(interpolate(cur_word.qload, cur_word.qslip));
            endcase
            if (cur_word.op == OP_QUERY) n_queries++;
            else n_writes++;
        end
    end

    always @(posedge clk)
        if (recv_block_left > 0) recv_block_left--;

    always @(negedge clk)
        m_tready <= rst_n && recv_block_left == 0 && $urandom_range(99) >= recv_stall_pct;

    always @(posedge clk) begin
        answer_t e;
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_answers.size() == 0)
                report("unexpected result", m_tdata[31:0], 32'h0);
            else begin
                e = expected_answers.pop_front();
                if (m_tdata[31:0] !== e.value) report("interpolated_value", m_tdata[31:0], e.value);
                if (m_tdata[32] !== e.load_out) report("load_outside", m_tdata[32], e.load_out);
                if (m_tdata[33] !== e.slip_clamp) report("slip_clamped", m_tdata[33], e.slip_clamp);
                n_load_out += e.load_out;
                n_slip_clamp += e.slip_clamp;
            end
        end
    end

    task automatic push_word(op_t op, int row, int col, logic signed [31:0] val,
                             logic signed [31:0] ql, logic signed [31:0] qs);
        word_t w;
        w.op = op;
        w.row = 6'(row);
        w.col = 4'(col);
        w.val = val;
        w.qload = ql;
        w.qslip = qs;
        if (op == OP_WRITE_LOAD) plan_load[col] = val;
        if (op == OP_WRITE_SLIP) plan_slip[row] = val;
        pending_words.push_back(w);
    endtask

    task automatic push_query(logic signed [31:0] ql, logic signed [31:0] qs);
        push_word(OP_QUERY, $urandom_range(63), $urandom_range(15), $urandom, ql, qs);
    endtask

    task automatic wait_drain();
        wait (pending_words.size() == 0 && !holding && expected_answers.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic cfg_write(logic idx, logic [6:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        if (idx == REG_LOAD_POINTS) load_used = data[4:0];
        else slip_used = data;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Axis layouts: 0 narrow sorted, 1 wide sorted with flat ends, 2 unsorted.
    task automatic fill_axes(int layout);
        longint v;
        int step_max;
        step_max = layout == 1 ? (1 << 28) : (1 << 18);
        v = layout == 1 ? 64'sd2147483647 : longint'($urandom_range(1 << 22)) - (1 << 21);
        for (int c = 0; c < 16; c++) begin
            push_word(OP_WRITE_LOAD, $urandom_range(63), c,
                      layout == 2 ? $urandom : 32'(sat32(v)), $urandom, $urandom);
            v -= $urandom_range(7) == 0 ? 0 : $urandom_range(step_max);
        end
        v = layout == 1 ? -64'sd2147483648 : longint'($urandom_range(1 << 20)) - (1 << 19);
        step_max = layout == 1 ? (1 << 26) : (1 << 16);
        for (int r = 0; r < 64; r++) begin
            push_word(OP_WRITE_SLIP, r, $urandom_range(15),
                      layout == 2 ? $urandom : 32'(sat32(v)), $urandom, $urandom);
            v += $urandom_range(7) == 0 ? 0 : $urandom_range(step_max);
        end
    endtask

    function automatic logic signed [31:0] grid_value(bit wide);
        case ($urandom_range(9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            default: return wide ? $urandom
                                 : 32'(longint'($urandom_range(1 << 21)) - (1 << 20));
        endcase
    endfunction

    function automatic logic signed [31:0] near_point(logic signed [31:0] pt);
        longint off;
        case ($urandom_range(5))
            0: return $urandom;
            1: return pt;
            default:
            begin
                off = longint'($urandom_range((1 << $urandom_range(24)) - 1));
                return 32'(sat32($urandom_range(1) ? pt + off : pt - off));
            end
        endcase
    endfunction

    task automatic random_items(int count, bit wide);
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(19))
                0: push_word(OP_WRITE_LOAD, $urandom_range(63), $urandom_range(15),
                             plan_load[$urandom_range(15)], $urandom, $urandom);
                1: push_word(OP_WRITE_SLIP, $urandom_range(63), $urandom_range(15),
                             plan_slip[$urandom_range(63)], $urandom, $urandom);
                2, 3, 4, 5, 6:
                    push_word(OP_WRITE_GRID, $urandom_range(63), $urandom_range(15),
                              grid_value(wide), $urandom, $urandom);
                default: push_query(near_point(plan_load[$urandom_range(15)]),
                                    near_point(plan_slip[$urandom_range(63)]));
            endcase
        end
    endtask

    initial begin
        int phase_send [5] = '{0, 75, 0, 33, 0};
        int phase_recv [5] = '{0, 0, 75, 33, 0};
        logic [4:0] phase_load [5] = '{5'd16, 5'd2, 5'd9, 5'd0, 5'd31};
        logic [6:0] phase_slip [5] = '{7'd64, 7'd2, 7'd37, 7'd127, 7'd1};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        fill_axes(0);
        for (int r = 0; r < 64; r++)
            for (int c = 0; c < 16; c++)
                push_word(OP_WRITE_GRID, r, c, grid_value(0), $urandom, $urandom);

        // Directed: axis ends, flat intervals, extreme coordinates.
        push_query(plan_load[0], plan_slip[0]);
        push_query(plan_load[15], plan_slip[63]);
        push_query(32'sh7fffffff, 32'sh7fffffff);
        push_query(32'sh80000000, 32'sh80000000);
        push_query(32'sh7fffffff, 32'sh80000000);
        push_query(32'sh80000000, 32'sh7fffffff);
        push_query(plan_load[0] + 1, plan_slip[63] + 1);
        push_query(plan_load[15] - 1, plan_slip[0] - 1);
        push_query(plan_load[7], plan_slip[31]);
        push_word(OP_WRITE_LOAD, 0, 5, plan_load[4], 0, 0);
        push_word(OP_WRITE_SLIP, 20, 0, plan_slip[19], 0, 0);
        push_query(plan_load[4], plan_slip[19]);
        push_word(OP_WRITE_GRID, 0, 0, 32'sh7fffffff, 0, 0);
        push_word(OP_WRITE_GRID, 0, 1, 32'sh80000000, 0, 0);
        push_word(OP_WRITE_GRID, 1, 0, 32'sh80000000, 0, 0);
        push_word(OP_WRITE_GRID, 1, 1, 32'sh7fffffff, 0, 0);
        push_query(32'sh7fffffff, plan_slip[0]);
        push_query(32'sh7fffffff, 32'sh80000000);
        push_query(plan_load[0], 32'sh80000000);
        wait_drain();

        for (int ph = 0; ph < 5; ph++) begin
            send_idle_pct = phase_send[ph];
            recv_stall_pct = phase_recv[ph];
            cfg_write(REG_LOAD_POINTS, {2'b0, phase_load[ph]});
            cfg_write(REG_SLIP_POINTS, phase_slip[ph]);
            if (ph > 0) fill_axes(ph == 4 ? 2 : ph % 2);
            if (ph == 2) recv_block_left = 3000;
            random_items(12, ph % 2);
            // The sender holds back until everything so far has come out.
            wait (pending_words.size() == 0 && !holding && expected_answers.size() == 0);
            random_items(12, ph % 2);
            wait_drain();
        end
        recv_block_left = 0;
        repeat (300) @(posedge clk);

        $display("Covered %0d queries and %0d table writes over five point-count settings,",
                 n_queries, n_writes);
        $display("with %0d load extrapolations and %0d slip clamps.", n_load_out, n_slip_clamp);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

endmodule
